>>> rtl/ngf_pkg.sv
// ----------------------------------------------------------------------------
// North gradient filter package
// Shared widths, register indexes, the divide-by-nine constants and the
// window tap type used by the filter lanes and the top level.
// ----------------------------------------------------------------------------
package ngf_pkg;

   // Channel byte width and the number of channel ports on the top level.
   localparam int CHAN_W    = 8;
   localparam int MAX_LANES = 3;

   // Signed window sum: the mask keeps it within -1275..1275.
   localparam int SUM_W = 12;

   // Division by nine as a multiply by a rounded-up reciprocal and a shift.
   // Exact for every non-negative sum up to 1275.
   localparam int DIV9_MUL_W = 13;
   localparam int DIV9_SHIFT = 16;
   localparam logic [DIV9_MUL_W-1:0] DIV9_MUL = 13'd7282;

   // Coordinate fields of the result.
   localparam int COORD_W = 11;

   // Configuration port.
   localparam int CSR_DATA_W  = 12;
   localparam int CSR_INDEX_W = 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_WIDTH  = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_HEIGHT = 1'd1;

   // Register reset values and the width used to compare sizes.
   localparam int WIDTH_RESET  = 640;
   localparam int HEIGHT_RESET = 480;
   localparam int DIM_CMP_W    = 14;
   localparam int DIM_MIN      = 3;

   // Nine channel bytes of the 3x3 window: [row][column], row 0 is the top,
   // column 0 is the oldest column.
   typedef logic [2:0][2:0][CHAN_W-1:0] taps_type;

endpackage

>>> rtl/ngf_ram.sv
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module ngf_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port; the data holds while the read is not enabled.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/ngf_lane.sv
// ----------------------------------------------------------------------------
// North gradient filter lane
// Applies the north gradient mask to one channel of the 3x3 window,
// registers the signed sum, then divides by nine and clamps at zero.
// ----------------------------------------------------------------------------
module ngf_lane (
   input  logic                         clock,
   input  logic                         load,
   input  ngf_pkg::taps_type            taps,
   output logic [ngf_pkg::CHAN_W-1:0]   result
);

   localparam int SUM_W  = ngf_pkg::SUM_W;
   localparam int PROD_W = SUM_W + ngf_pkg::DIV9_MUL_W;

   logic signed [SUM_W-1:0] sum_in;
   logic signed [SUM_W-1:0] sum_ff;
   logic [PROD_W-1:0]       prod;

   // Mask: top row +1 +1 +1, middle row +1 -2 +1, bottom row -1 -1 -1.
   always_comb begin
      sum_in = $signed(SUM_W'(taps[0][0])) + $signed(SUM_W'(taps[0][1]))
             + $signed(SUM_W'(taps[0][2])) + $signed(SUM_W'(taps[1][0]))
             + $signed(SUM_W'(taps[1][2]))
             - $signed(SUM_W'({taps[1][1], 1'b0}))
             - $signed(SUM_W'(taps[2][0])) - $signed(SUM_W'(taps[2][1]))
             - $signed(SUM_W'(taps[2][2]));
   end

   always_ff @(posedge clock) begin
      if (load) begin
         sum_ff <= sum_in;
      end
   end

   // Divide by nine through the reciprocal; a sum at or below zero gives zero.
   assign prod = PROD_W'(unsigned'(sum_ff)) * PROD_W'(ngf_pkg::DIV9_MUL);

   always_comb begin
      if (sum_ff > 0) begin
         result = prod[ngf_pkg::DIV9_SHIFT +: ngf_pkg::CHAN_W];
      end else begin
         result = '0;
      end
   end

endmodule

>>> rtl/north_gradient_filter_3x3_rgb.sv
// Path: an accepted pixel passes stage one, the lane sums and the output register to rsp_.
// Throughput: one pixel per cycle when not stalled; one line store read and write a pixel.
// Border pixels pass through the pipeline but produce no transaction.
// Reset: synchronous; afterwards a clearing pass zeroes every line store address,
// during which req_ready stays low. Configuration writes are taken throughout.
// ----------------------------------------------------------------------------
// North gradient 3x3 filter for an RGB pixel stream
// Keeps two image rows in a line store and a 3x3 window, runs one filter lane
// per channel and merges the lane results with the centre coordinates and
// the frame end flag into the output register.
// ----------------------------------------------------------------------------
module north_gradient_filter_3x3_rgb #(
   parameter int MAX_WIDTH  = 2048,
   parameter int MAX_HEIGHT = 2048,
   parameter int CHANNELS   = 3
) (
   input  logic                              clock,
   input  logic                              reset,
   // Pixel input channel
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [ngf_pkg::CHAN_W-1:0]        req_red_in,
   input  logic [ngf_pkg::CHAN_W-1:0]        req_green_in,
   input  logic [ngf_pkg::CHAN_W-1:0]        req_blue_in,
   // Result channel
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [ngf_pkg::CHAN_W-1:0]        rsp_red_out,
   output logic [ngf_pkg::CHAN_W-1:0]        rsp_green_out,
   output logic [ngf_pkg::CHAN_W-1:0]        rsp_blue_out,
   output logic [ngf_pkg::COORD_W-1:0]       rsp_centre_column,
   output logic [ngf_pkg::COORD_W-1:0]       rsp_centre_row,
   output logic                              rsp_frame_end,
   // Configuration write port
   input  logic                              csr_wr_en,
   input  logic [ngf_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [ngf_pkg::CSR_DATA_W-1:0]    csr_wr_data
);

   localparam int CHAN_W  = ngf_pkg::CHAN_W;
   localparam int COORD_W = ngf_pkg::COORD_W;
   localparam int CMP_W   = ngf_pkg::DIM_CMP_W;
   localparam int LANES   = (CHANNELS < ngf_pkg::MAX_LANES) ? CHANNELS : ngf_pkg::MAX_LANES;
   localparam int PIX_W   = LANES * CHAN_W;
   localparam int COL_W   = $clog2(MAX_WIDTH);
   localparam int ROW_W   = $clog2(MAX_HEIGHT);
   localparam int W_RESET_LAST =
      ((ngf_pkg::WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : ngf_pkg::WIDTH_RESET) - 1;
   localparam int H_RESET_LAST =
      ((ngf_pkg::HEIGHT_RESET > MAX_HEIGHT) ? MAX_HEIGHT : ngf_pkg::HEIGHT_RESET) - 1;

   // Last column and row index of the frame, already clamped.
   logic [COL_W-1:0] w_last_ff, w_last_in;
   logic [ROW_W-1:0] h_last_ff, h_last_in;
   logic [CMP_W-1:0] dim_value;

   // Position of the next incoming pixel.
   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic             row_end, last_row;

   // Line store clearing pass.
   logic             clr_active_ff;
   logic [COL_W-1:0] clr_addr_ff;

   // Pipeline stage one: pixel, position, and the line store read data.
   logic             s1_valid_ff;
   logic [PIX_W-1:0] s1_pix_ff;
   logic [COL_W-1:0] s1_col_ff;
   logic [ROW_W-1:0] s1_row_ff;
   logic             s1_emit_ff;
   logic             s1_fend_ff;

   // Pipeline stage two: lane sums are registered inside the lanes.
   logic             s2_valid_ff;
   logic [COL_W-1:0] s2_col_ff;
   logic [ROW_W-1:0] s2_row_ff;
   logic             s2_emit_ff;
   logic             s2_fend_ff;

   // Output register.
   logic                              rsp_valid_ff;
   logic [ngf_pkg::MAX_LANES-1:0][CHAN_W-1:0] rsp_chan_ff;
   logic [COORD_W-1:0]                rsp_col_ff;
   logic [COORD_W-1:0]                rsp_row_ff;
   logic                              rsp_fend_ff;

   // Flow control.
   logic accept, s1_adv, s2_adv, s1_room, s2_room, out_room;

   // Window and line store.
   logic [PIX_W-1:0]   win_ff [6];
   logic [2*PIX_W-1:0] ram_rd_data;
   logic [PIX_W-1:0]   top_pix, mid_pix;
   logic [ngf_pkg::MAX_LANES-1:0][CHAN_W-1:0] in_bytes;
   logic [PIX_W-1:0]   pix_in;
   logic               ram_wr_en;
   logic [COL_W-1:0]   ram_wr_addr;
   logic [2*PIX_W-1:0] ram_wr_data;
   logic [ngf_pkg::MAX_LANES-1:0][CHAN_W-1:0] lane_result;

   // ------------------------------------------------------------------------
   // Configuration: clamp each size into its legal range as it is written.
   // ------------------------------------------------------------------------
   assign dim_value = CMP_W'(csr_wr_data);

   always_comb begin
      w_last_in = w_last_ff;
      h_last_in = h_last_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            ngf_pkg::CSR_IMAGE_WIDTH: begin
               if (dim_value < CMP_W'(ngf_pkg::DIM_MIN)) begin
                  w_last_in = COL_W'(ngf_pkg::DIM_MIN - 1);
               end else if (dim_value > CMP_W'(MAX_WIDTH)) begin
                  w_last_in = COL_W'(MAX_WIDTH - 1);
               end else begin
                  w_last_in = COL_W'(dim_value - CMP_W'(1));
               end
            end
            ngf_pkg::CSR_IMAGE_HEIGHT: begin
               if (dim_value < CMP_W'(ngf_pkg::DIM_MIN)) begin
                  h_last_in = ROW_W'(ngf_pkg::DIM_MIN - 1);
               end else if (dim_value > CMP_W'(MAX_HEIGHT)) begin
                  h_last_in = ROW_W'(MAX_HEIGHT - 1);
               end else begin
                  h_last_in = ROW_W'(dim_value - CMP_W'(1));
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         w_last_ff <= COL_W'(W_RESET_LAST);
         h_last_ff <= ROW_W'(H_RESET_LAST);
      end else begin
         w_last_ff <= w_last_in;
         h_last_ff <= h_last_in;
      end
   end

   // ------------------------------------------------------------------------
   // Flow control: each stage moves when the stage after it has room.
   // Stage two drops a border pixel without using the output register.
   // ------------------------------------------------------------------------
   assign out_room  = !rsp_valid_ff || rsp_ready;
   assign s2_adv    = s2_valid_ff && (!s2_emit_ff || out_room);
   assign s2_room   = !s2_valid_ff || s2_adv;
   assign s1_adv    = s1_valid_ff && s2_room;
   assign s1_room   = !s1_valid_ff || s2_room;
   assign req_ready = s1_room && !clr_active_ff;
   assign accept    = req_valid && req_ready;

   // ------------------------------------------------------------------------
   // Raster position of the next pixel.
   // ------------------------------------------------------------------------
   assign row_end  = (col_ff >= w_last_ff);
   assign last_row = (row_ff >= h_last_ff);

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (row_end) begin
            col_in = '0;
            row_in = last_row ? '0 : row_ff + ROW_W'(1);
         end else begin
            col_in = col_ff + COL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // ------------------------------------------------------------------------
   // Clearing pass over the line store after reset.
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_active_ff <= 1'b1;
         clr_addr_ff   <= '0;
      end else if (clr_active_ff) begin
         clr_addr_ff <= clr_addr_ff + COL_W'(1);
         if (clr_addr_ff == COL_W'(MAX_WIDTH - 1)) begin
            clr_active_ff <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Line store: the older and the newer row share one address per column.
   // The read is issued when a pixel is accepted; the write happens when the
   // pixel leaves stage one.
   // ------------------------------------------------------------------------
   assign in_bytes[0] = req_red_in;
   assign in_bytes[1] = req_green_in;
   assign in_bytes[2] = req_blue_in;
   assign pix_in      = PIX_W'(in_bytes[LANES-1:0]);

   assign top_pix = ram_rd_data[2*PIX_W-1:PIX_W];
   assign mid_pix = ram_rd_data[PIX_W-1:0];

   always_comb begin
      if (clr_active_ff) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = clr_addr_ff;
         ram_wr_data = '0;
      end else begin
         ram_wr_en   = s1_adv;
         ram_wr_addr = s1_col_ff;
         ram_wr_data = {mid_pix, s1_pix_ff};
      end
   end

   ngf_ram #(
      .WIDTH (2 * PIX_W),
      .DEPTH (MAX_WIDTH)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (accept),
      .rd_addr (col_ff),
      .rd_data (ram_rd_data)
   );

   // ------------------------------------------------------------------------
   // Stage one registers.
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_room) begin
         s1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pix_ff  <= pix_in;
         s1_col_ff  <= col_ff;
         s1_row_ff  <= row_ff;
         s1_emit_ff <= (row_ff >= ROW_W'(2)) && (col_ff >= COL_W'(2));
         s1_fend_ff <= row_end && last_row;
      end
   end

   // Window shift: older column moves out, the new column is top, mid, cur.
   always_ff @(posedge clock) begin
      if (s1_adv) begin
         win_ff[0] <= win_ff[3];
         win_ff[1] <= win_ff[4];
         win_ff[2] <= win_ff[5];
         win_ff[3] <= top_pix;
         win_ff[4] <= mid_pix;
         win_ff[5] <= s1_pix_ff;
      end
   end

   // ------------------------------------------------------------------------
   // Filter lanes, one per channel; missing channels read as zero.
   // ------------------------------------------------------------------------
   for (genvar k = 0; k < ngf_pkg::MAX_LANES; k++) begin : g_lane
      if (k < LANES) begin : g_on
         ngf_pkg::taps_type taps;

         assign taps[0][0] = win_ff[0][k*CHAN_W +: CHAN_W];
         assign taps[0][1] = win_ff[3][k*CHAN_W +: CHAN_W];
         assign taps[0][2] = top_pix[k*CHAN_W +: CHAN_W];
         assign taps[1][0] = win_ff[1][k*CHAN_W +: CHAN_W];
         assign taps[1][1] = win_ff[4][k*CHAN_W +: CHAN_W];
         assign taps[1][2] = mid_pix[k*CHAN_W +: CHAN_W];
         assign taps[2][0] = win_ff[2][k*CHAN_W +: CHAN_W];
         assign taps[2][1] = win_ff[5][k*CHAN_W +: CHAN_W];
         assign taps[2][2] = s1_pix_ff[k*CHAN_W +: CHAN_W];

         ngf_lane u_lane (
            .clock  (clock),
            .load   (s1_adv),
            .taps   (taps),
            .result (lane_result[k])
         );
      end else begin : g_off
         assign lane_result[k] = '0;
      end
   end

   // ------------------------------------------------------------------------
   // Stage two registers.
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_room) begin
         s2_valid_ff <= s1_adv;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         s2_col_ff  <= s1_col_ff;
         s2_row_ff  <= s1_row_ff;
         s2_emit_ff <= s1_emit_ff;
         s2_fend_ff <= s1_fend_ff;
      end
   end

   // ------------------------------------------------------------------------
   // Merge stage: lane results and the centre position form one transaction.
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_room) begin
         rsp_valid_ff <= s2_adv && s2_emit_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_room && s2_adv && s2_emit_ff) begin
         rsp_chan_ff <= lane_result;
         rsp_col_ff  <= COORD_W'(s2_col_ff) - COORD_W'(1);
         rsp_row_ff  <= COORD_W'(s2_row_ff) - COORD_W'(1);
         rsp_fend_ff <= s2_fend_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_red_out       = rsp_chan_ff[0];
   assign rsp_green_out     = rsp_chan_ff[1];
   assign rsp_blue_out      = rsp_chan_ff[2];
   assign rsp_centre_column = rsp_col_ff;
   assign rsp_centre_row    = rsp_row_ff;
   assign rsp_frame_end     = rsp_fend_ff;

endmodule
